// ===== hw/rtl/sv39ptw_pkg.sv =====
// Shared types, codes and widths of the Sv39 page table walker.
package sv39ptw_pkg;

  localparam int unsigned TablePagesDef  = 16;
  localparam int unsigned EntriesPerPage = 512;
  localparam int unsigned IdxW           = 9;
  localparam int unsigned PpnW           = 44;
  localparam int unsigned PteW           = 64;
  localparam int unsigned VaW            = 64;
  localparam int unsigned InDataW        = 144;
  localparam int unsigned OutDataW       = 80;
  localparam int unsigned CfgAddrW       = 4;
  localparam int unsigned CfgDataW       = 64;

  typedef enum logic {
    OpWrite  = 1'b0,
    OpLookup = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatOk        = 2'd0,
    StatUnmapped  = 2'd1,
    StatTooLarge  = 2'd2,
    StatOutside   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    WkIdle   = 2'd0,
    WkCheck  = 2'd1,
    WkRead   = 2'd2,
    WkResult = 2'd3
  } walk_state_e;

  typedef enum logic {
    RegRoot = 1'b0,
    RegBase = 1'b1
  } reg_sel_e;

  typedef struct packed {
    status_e          status;
    logic [1:0]       level;
    logic [3:0]       slot;
    logic [IdxW-1:0]  index;
    logic [PteW-1:0]  value;
  } result_t;

endpackage

// ===== hw/rtl/sv39ptw_ram.sv =====
// Generic single-port RAM with registered read data.
module sv39ptw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sv39_page_table_walker_unit.sv =====
// Top level of the Sv39 page table walker with its table store and walk sequencer.
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tuser opcode, tdata write or lookup item
//  m_axis    out        m_axis_tvalid/tready       tuser status, tdata found entry
//  apb       in         psel/penable/pready        root_page at 0x0, store_base_page at 0x8
//
// A write item and an oversized lookup go from acceptance straight to the result stage; for each
// level read a lookup takes a range check and address step, then the registered read of the single
// table store port; a failed range check goes straight to the result stage. Every item then passes
// the result stage and the output register.
// Reset clears the sequencer and both configuration registers; the table store is not cleared.
// A finished item waits in the result stage until the output register is free.
module sv39_page_table_walker_unit #(
  parameter int unsigned TABLE_PAGES = sv39ptw_pkg::TablePagesDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // virt_addr, page_slot, entry_index, entry_data, zero pad
  input  logic [sv39ptw_pkg::InDataW-1:0]       s_axis_tdata,
  // opcode
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // found_level, found_slot, found_index, found_value, zero pad
  output logic [sv39ptw_pkg::OutDataW-1:0]      m_axis_tdata,
  // status
  output logic [1:0]                            m_axis_tuser,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sv39ptw_pkg::CfgAddrW-1:0]      paddr,
  input  logic [sv39ptw_pkg::CfgDataW-1:0]      pwdata,
  output logic [sv39ptw_pkg::CfgDataW-1:0]      prdata,
  output logic                                  pready
);

  import sv39ptw_pkg::*;

  localparam int unsigned SlotW  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned Depth  = TABLE_PAGES * EntriesPerPage;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned MemAW  = SlotW + IdxW;

  walk_state_e          state_q, state_d;
  logic [PpnW-1:0]      root_q, base_q;
  logic [PpnW-1:0]      page_q, page_d;
  logic [26:0]          va_q, va_d;
  logic [1:0]           lvl_q, lvl_d;
  logic [SlotW-1:0]     slot_q, slot_d;
  result_t              res_q, res_d;
  result_t              out_q;
  logic                 m_valid_q, m_valid_d;

  logic                 s_acc;
  logic                 cfg_we;
  op_e                  in_op;
  logic [VaW-1:0]       in_va;
  logic [3:0]           in_slot;
  logic [IdxW-1:0]      in_idx;
  logic [PteW-1:0]      in_data;
  logic                 in_too_large;
  logic                 in_slot_ok;
  logic [PpnW:0]        diff;
  logic                 out_range;
  logic [SlotW-1:0]     diff_slot;
  logic [IdxW-1:0]      cur_idx;
  logic                 pte_ptr;
  logic                 out_load;

  logic                 mem_en, mem_we;
  logic [MemAW-1:0]     mem_addr;
  logic [PteW-1:0]      mem_rdata;

  assign s_acc        = s_axis_tvalid && s_axis_tready;
  assign in_op        = op_e'(s_axis_tuser);
  assign in_va        = s_axis_tdata[63:0];
  assign in_slot      = s_axis_tdata[67:64];
  assign in_idx       = s_axis_tdata[76:68];
  assign in_data      = s_axis_tdata[140:77];
  assign in_too_large = (in_va[63:39] != '0);
  assign in_slot_ok   = (32'(in_slot) < TABLE_PAGES);

  assign diff      = {1'b0, page_q} - {1'b0, base_q};
  assign out_range = diff[PpnW] || (diff[PpnW-1:0] >= PpnW'(TABLE_PAGES));
  assign diff_slot = diff[SlotW-1:0];
  assign pte_ptr   = mem_rdata[0] && (mem_rdata[3:1] == 3'b000);

  always_comb begin
    unique case (lvl_q)
      2'd2:    cur_idx = va_q[26:18];
      2'd1:    cur_idx = va_q[17:9];
      default: cur_idx = va_q[8:0];
    endcase
  end

  assign s_axis_tready = (state_q == WkIdle);
  assign out_load      = (state_q == WkResult) && (!m_valid_q || m_axis_tready);
  assign m_valid_d     = out_load || (m_valid_q && !m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      WkIdle: begin
        if (s_acc) begin
          state_d = (in_op == OpLookup && !in_too_large) ? WkCheck : WkResult;
        end
      end
      WkCheck: begin
        state_d = out_range ? WkResult : WkRead;
      end
      WkRead: begin
        state_d = (lvl_q != 2'd0 && pte_ptr) ? WkCheck : WkResult;
      end
      WkResult: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = WkIdle;
        end
      end
      default: state_d = WkIdle;
    endcase
  end

  always_comb begin
    res_d    = res_q;
    page_d   = page_q;
    va_d     = va_q;
    lvl_d    = lvl_q;
    slot_d   = slot_q;
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = {diff_slot, cur_idx};
    unique case (state_q)
      WkIdle: begin
        if (s_acc) begin
          va_d   = in_va[38:12];
          page_d = root_q;
          lvl_d  = 2'd2;
          if (in_op == OpWrite) begin
            mem_addr = {SlotW'(in_slot), in_idx};
            mem_en   = in_slot_ok;
            mem_we   = in_slot_ok;
            res_d    = '{status: in_slot_ok ? StatOk : StatOutside, level: 2'd0,
                         slot: in_slot, index: in_idx,
                         value: in_slot_ok ? in_data : '0};
          end else begin
            res_d = '{status: StatTooLarge, level: 2'd0, slot: 4'd0,
                      index: '0, value: '0};
          end
        end
      end
      WkCheck: begin
        slot_d = diff_slot;
        mem_en = !out_range;
        res_d  = '{status: StatOutside, level: lvl_q, slot: 4'd0,
                   index: cur_idx, value: '0};
      end
      WkRead: begin
        if (lvl_q == 2'd0) begin
          res_d = '{status: StatOk, level: 2'd0, slot: 4'(slot_q),
                    index: cur_idx, value: mem_rdata};
        end else if (!mem_rdata[0]) begin
          res_d = '{status: StatUnmapped, level: lvl_q, slot: 4'(slot_q),
                    index: cur_idx, value: '0};
        end else if (mem_rdata[3:1] != 3'b000) begin
          res_d = '{status: StatOk, level: lvl_q, slot: 4'(slot_q),
                    index: cur_idx, value: mem_rdata};
        end else begin
          page_d = mem_rdata[53:10];
          lvl_d  = lvl_q - 2'd1;
        end
      end
      WkResult: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= WkIdle;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    va_q   <= va_d;
    lvl_q  <= lvl_d;
    slot_q <= slot_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      base_q <= '0;
    end else if (cfg_we) begin
      if (reg_sel_e'(paddr[3]) == RegRoot) begin
        root_q <= pwdata[PpnW-1:0];
      end else begin
        base_q <= pwdata[PpnW-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (reg_sel_e'(paddr[3]) == RegRoot) ? CfgDataW'(root_q) : CfgDataW'(base_q);

  sv39ptw_ram #(
    .Width (PteW),
    .Depth (Depth)
  ) u_table_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (AddrW'(mem_addr)),
    .wdata_i (in_data),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {1'b0, out_q.value, out_q.index, out_q.slot, out_q.level};

endmodule

// ===== hw/rtl/sv39ptw_checker.sv =====
// Port-level checker for the Sv39 page table walker, bound to the top level.
module sv39ptw_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sv39ptw_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);

  import sv39ptw_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Result changed or dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("Input taken again right after an item was accepted.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (op_e'(s_axis_tuser) == OpWrite) && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("Write item did not produce its result on time.");

endmodule

bind sv39_page_table_walker_unit sv39ptw_checker u_sv39ptw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
